@@ src/lbs_pkg.sv @@
// ============================================================================
// lbs_pkg: shared types, constants and helpers for the skinning core
// Micro-op table, sequencer states, saturation helpers and sizing constants.
// ============================================================================
package lbs_pkg;

    // sizing
    localparam int MAX_BONES  = 64;
    localparam int MAX_INFL   = 4;
    localparam int FRAC_BITS  = 16;
    localparam int W_SHIFT    = 16;
    localparam int BONE_ELEMS = 12;
    localparam int BONE_W     = 6;
    localparam int ELEM_W     = 4;
    localparam int DATA_W     = 32;
    localparam int WGT_W      = 17;
    localparam int ACC_W      = 48;
    localparam int SUM_W      = 50;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int DIVD_W     = DATA_W + FRAC_BITS;
    localparam int DET_W      = SUM_W;
    localparam int QUO_W      = DIVD_W + 1;
    localparam int RAM_DEPTH  = MAX_BONES * BONE_ELEMS;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int CNT_W      = $clog2(MAX_INFL + 1);
    localparam int UOP_W      = 6;
    localparam int IDX_W      = 4;

    localparam logic [WGT_W-1:0]  WGT_ONE      = WGT_W'(1 << W_SHIFT);
    localparam logic [UOP_W-1:0]  POS_LAST_UOP = UOP_W'(14);
    localparam logic [UOP_W-1:0]  LAST_UOP     = UOP_W'(47);
    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]  A_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  A_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // request types
    localparam logic REQ_MATRIX = 1'b0;
    localparam logic REQ_INFL   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_FIN
    } state_t;

    // micro-op fields
    typedef enum logic [1:0] {A_RAM, A_COF, A_VAL} a_src_t;
    typedef enum logic [2:0] {B_RAM, B_POS, B_NRM, B_ONE, B_WGT} b_src_t;
    typedef enum logic [1:0] {M_NEW, M_ADD, M_SUB} mode_t;
    typedef enum logic [2:0] {F_NONE, F_VAL, F_ACC, F_COF, F_DET, F_DIV} fin_t;

    typedef struct packed {
        a_src_t             a_src;
        logic [IDX_W-1:0]   a_idx;
        b_src_t             b_src;
        logic [IDX_W-1:0]   b_idx;
        mode_t              mode;
        fin_t               fin;
        logic [IDX_W-1:0]   k;
    } uop_t;

    function automatic uop_t mk(input a_src_t as, input int ai, input b_src_t bs,
                                input int bi, input mode_t md, input fin_t fn,
                                input int kk);
        uop_t u;
        u.a_src = as;
        u.a_idx = IDX_W'(ai);
        u.b_src = bs;
        u.b_idx = IDX_W'(bi);
        u.mode  = md;
        u.fin   = fn;
        u.k     = IDX_W'(kk);
        return u;
    endfunction

    // micro-program: position rows, cofactors, determinant, normal rows
    function automatic uop_t uop_rom(input logic [UOP_W-1:0] idx);
        uop_t u;
        unique case (idx)
            6'd0:  u = mk(A_RAM, 0,  B_POS, 0,  M_NEW, F_NONE, 0);
            6'd1:  u = mk(A_RAM, 1,  B_POS, 1,  M_ADD, F_NONE, 0);
            6'd2:  u = mk(A_RAM, 2,  B_POS, 2,  M_ADD, F_NONE, 0);
            6'd3:  u = mk(A_RAM, 3,  B_ONE, 0,  M_ADD, F_VAL,  0);
            6'd4:  u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  0);
            6'd5:  u = mk(A_RAM, 4,  B_POS, 0,  M_NEW, F_NONE, 0);
            6'd6:  u = mk(A_RAM, 5,  B_POS, 1,  M_ADD, F_NONE, 0);
            6'd7:  u = mk(A_RAM, 6,  B_POS, 2,  M_ADD, F_NONE, 0);
            6'd8:  u = mk(A_RAM, 7,  B_ONE, 0,  M_ADD, F_VAL,  0);
            6'd9:  u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  1);
            6'd10: u = mk(A_RAM, 8,  B_POS, 0,  M_NEW, F_NONE, 0);
            6'd11: u = mk(A_RAM, 9,  B_POS, 1,  M_ADD, F_NONE, 0);
            6'd12: u = mk(A_RAM, 10, B_POS, 2,  M_ADD, F_NONE, 0);
            6'd13: u = mk(A_RAM, 11, B_ONE, 0,  M_ADD, F_VAL,  0);
            6'd14: u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  2);
            6'd15: u = mk(A_RAM, 5,  B_RAM, 10, M_NEW, F_NONE, 0);
            6'd16: u = mk(A_RAM, 6,  B_RAM, 9,  M_SUB, F_COF,  0);
            6'd17: u = mk(A_RAM, 6,  B_RAM, 8,  M_NEW, F_NONE, 0);
            6'd18: u = mk(A_RAM, 4,  B_RAM, 10, M_SUB, F_COF,  1);
            6'd19: u = mk(A_RAM, 4,  B_RAM, 9,  M_NEW, F_NONE, 0);
            6'd20: u = mk(A_RAM, 5,  B_RAM, 8,  M_SUB, F_COF,  2);
            6'd21: u = mk(A_RAM, 2,  B_RAM, 9,  M_NEW, F_NONE, 0);
            6'd22: u = mk(A_RAM, 1,  B_RAM, 10, M_SUB, F_COF,  3);
            6'd23: u = mk(A_RAM, 0,  B_RAM, 10, M_NEW, F_NONE, 0);
            6'd24: u = mk(A_RAM, 2,  B_RAM, 8,  M_SUB, F_COF,  4);
            6'd25: u = mk(A_RAM, 1,  B_RAM, 8,  M_NEW, F_NONE, 0);
            6'd26: u = mk(A_RAM, 0,  B_RAM, 9,  M_SUB, F_COF,  5);
            6'd27: u = mk(A_RAM, 1,  B_RAM, 6,  M_NEW, F_NONE, 0);
            6'd28: u = mk(A_RAM, 2,  B_RAM, 5,  M_SUB, F_COF,  6);
            6'd29: u = mk(A_RAM, 2,  B_RAM, 4,  M_NEW, F_NONE, 0);
            6'd30: u = mk(A_RAM, 0,  B_RAM, 6,  M_SUB, F_COF,  7);
            6'd31: u = mk(A_RAM, 0,  B_RAM, 5,  M_NEW, F_NONE, 0);
            6'd32: u = mk(A_RAM, 1,  B_RAM, 4,  M_SUB, F_COF,  8);
            6'd33: u = mk(A_COF, 0,  B_RAM, 0,  M_NEW, F_NONE, 0);
            6'd34: u = mk(A_COF, 1,  B_RAM, 1,  M_ADD, F_NONE, 0);
            6'd35: u = mk(A_COF, 2,  B_RAM, 2,  M_ADD, F_DET,  0);
            6'd36: u = mk(A_COF, 0,  B_NRM, 0,  M_NEW, F_NONE, 0);
            6'd37: u = mk(A_COF, 1,  B_NRM, 1,  M_ADD, F_NONE, 0);
            6'd38: u = mk(A_COF, 2,  B_NRM, 2,  M_ADD, F_DIV,  0);
            6'd39: u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  3);
            6'd40: u = mk(A_COF, 3,  B_NRM, 0,  M_NEW, F_NONE, 0);
            6'd41: u = mk(A_COF, 4,  B_NRM, 1,  M_ADD, F_NONE, 0);
            6'd42: u = mk(A_COF, 5,  B_NRM, 2,  M_ADD, F_DIV,  0);
            6'd43: u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  4);
            6'd44: u = mk(A_COF, 6,  B_NRM, 0,  M_NEW, F_NONE, 0);
            6'd45: u = mk(A_COF, 7,  B_NRM, 1,  M_ADD, F_NONE, 0);
            6'd46: u = mk(A_COF, 8,  B_NRM, 2,  M_ADD, F_DIV,  0);
            6'd47: u = mk(A_VAL, 0,  B_WGT, 0,  M_NEW, F_ACC,  5);
            default: u = mk(A_VAL, 0, B_ONE, 0,  M_NEW, F_NONE, 0);
        endcase
        return u;
    endfunction

    // bone element address
    function automatic logic [RAM_AW-1:0] bone_addr(input logic [BONE_W-1:0] bone,
                                                    input logic [IDX_W-1:0] el);
        return RAM_AW'(int'(bone) * BONE_ELEMS + int'(el));
    endfunction

    // saturation helpers
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
        if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1)
            return x[DATA_W-1:0];
        return x[SUM_W-1] ? D_MIN : D_MAX;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_quo(input logic signed [QUO_W-1:0] x);
        if (x[QUO_W-1:DATA_W-1] == '0 || x[QUO_W-1:DATA_W-1] == '1)
            return x[DATA_W-1:0];
        return x[QUO_W-1] ? D_MIN : D_MAX;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
        if (x[ACC_W-1:DATA_W-1] == '0 || x[ACC_W-1:DATA_W-1] == '1)
            return x[DATA_W-1:0];
        return x[ACC_W-1] ? D_MIN : D_MAX;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W:0] x);
        if (x[ACC_W] == x[ACC_W-1])
            return x[ACC_W-1:0];
        return x[ACC_W] ? A_MIN : A_MAX;
    endfunction

endpackage

@@ src/lbs_bone_ram.sv @@
// ============================================================================
// lbs_bone_ram: bone matrix store
// One write port, two registered read ports.
// ============================================================================
module lbs_bone_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    output logic [WIDTH-1:0] rdata0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ src/lbs_div.sv @@
// ============================================================================
// lbs_div: serial signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ============================================================================
module lbs_div
    import lbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIVD_W-1:0] dividend,
    input  logic signed [DET_W-1:0]  divisor,
    output logic                     done,
    output logic signed [QUO_W-1:0]  quotient
);

    localparam int CW = $clog2(DIVD_W + 1);

    logic [DET_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] num_reg;
    logic [DET_W-1:0]  den_reg;
    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [DET_W:0]    trial;
    logic [DET_W:0]    shifted;

    // trial subtract of the next partial remainder
    assign shifted = {rem_reg, num_reg[DIVD_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DIVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= dividend[DIVD_W-1] ? DIVD_W'(-dividend) : dividend;
            den_reg <= divisor[DET_W-1] ? DET_W'(-divisor) : divisor;
            neg_reg <= dividend[DIVD_W-1] ^ divisor[DET_W-1];
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= trial[DET_W] ? shifted[DET_W-1:0] : trial[DET_W-1:0];
            num_reg <= {num_reg[DIVD_W-2:0], ~trial[DET_W]};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -QUO_W'({1'b0, num_reg}) : QUO_W'({1'b0, num_reg});

endmodule

@@ src/linear_blend_skinning_core.sv @@
// ============================================================================
// linear_blend_skinning_core: fixed-point linear blend skinning
// Bone store, micro-sequenced shared multiplier, serial divider.
// ============================================================================
// A vertex influence runs on one shared 32x32 multiplier stepped by a
// micro-program, each multiply passing through the read, multiply and
// accumulate steps; with normals on, each of the three normal components
// also waits on the serial divider. Zero-weight or surplus influences go
// straight to the finish step. The block takes no new word until the
// current one is done; a finished vertex sits in the output register while
// the next words are taken, and only a second finished vertex waits for it
// to drain. Bone elements that were never written read back as undefined.
module linear_blend_skinning_core
    import lbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [BONE_W-1:0]        bone_index,
    input  logic [ELEM_W-1:0]        matrix_element,
    input  logic signed [DATA_W-1:0] matrix_value,
    input  logic signed [DATA_W-1:0] pos_x,
    input  logic signed [DATA_W-1:0] pos_y,
    input  logic signed [DATA_W-1:0] pos_z,
    input  logic signed [DATA_W-1:0] nrm_x,
    input  logic signed [DATA_W-1:0] nrm_y,
    input  logic signed [DATA_W-1:0] nrm_z,
    input  logic [WGT_W-1:0]         weight,
    input  logic                     last_of_vertex,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_pos_x,
    output logic signed [DATA_W-1:0] out_pos_y,
    output logic signed [DATA_W-1:0] out_pos_z,
    output logic signed [DATA_W-1:0] out_nrm_x,
    output logic signed [DATA_W-1:0] out_nrm_y,
    output logic signed [DATA_W-1:0] out_nrm_z,
    output logic                     touched,
    output logic                     singular_seen
);

    state_t                    state_reg, state_next;
    logic [UOP_W-1:0]          op_reg, op_next;
    uop_t                      uop;

    logic [BONE_W-1:0]         bone_reg;
    logic signed [DATA_W-1:0]  pos_reg [3];
    logic signed [DATA_W-1:0]  nrm_reg [3];
    logic [WGT_W-1:0]          w_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DATA_W-1:0]  val_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic signed [DATA_W-1:0]  cof_reg [9];
    logic signed [ACC_W-1:0]   acc_reg [6];
    logic                      touched_reg;
    logic                      singular_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      normals_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_data_reg [6];
    logic                      out_touched_reg;
    logic                      out_singular_reg;

    logic                      in_accept;
    logic [WGT_W-1:0]          w_clamp;
    logic                      apply_c;
    logic                      ram_we;
    logic [DATA_W-1:0]         ram_rd0, ram_rd1;
    logic signed [DATA_W-1:0]  a_op, b_op;
    logic signed [SUM_W-1:0]   qv, sum_next;
    logic signed [ACC_W:0]     wv;
    logic                      det_zero;
    logic                      div_start, div_done;
    logic signed [QUO_W-1:0]   div_q;
    logic signed [DIVD_W-1:0]  div_num;
    logic                      emit;

    assign uop       = uop_rom(op_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign w_clamp   = (weight > WGT_ONE) ? WGT_ONE : weight;
    assign apply_c   = (int'(count_reg) < MAX_INFL) && (w_clamp != '0)
                       && (int'(bone_index) < MAX_BONES);
    assign ram_we    = in_accept && (req_type == REQ_MATRIX)
                       && (int'(bone_index) < MAX_BONES)
                       && (int'(matrix_element) < BONE_ELEMS);

    // bone store
    lbs_bone_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (bone_addr(bone_index, matrix_element)),
        .wdata  (matrix_value),
        .raddr0 (bone_addr(bone_reg, uop.a_idx)),
        .rdata0 (ram_rd0),
        .raddr1 (bone_addr(bone_reg, uop.b_idx)),
        .rdata1 (ram_rd1)
    );

    // operand select
    always_comb
    begin
        unique case (uop.a_src)
            A_RAM:   a_op = ram_rd0;
            A_COF:   a_op = cof_reg[uop.a_idx];
            A_VAL:   a_op = val_reg;
            default: a_op = val_reg;
        endcase
        unique case (uop.b_src)
            B_RAM:   b_op = ram_rd1;
            B_POS:   b_op = pos_reg[uop.b_idx[1:0]];
            B_NRM:   b_op = nrm_reg[uop.b_idx[1:0]];
            B_ONE:   b_op = Q_ONE;
            B_WGT:   b_op = DATA_W'(w_reg);
            default: b_op = Q_ONE;
        endcase
    end

    // product scaling and running sum
    assign qv = SUM_W'(prod_reg >>> FRAC_BITS);
    assign wv = (ACC_W+1)'(prod_reg >>> W_SHIFT);
    always_comb
    begin
        unique case (uop.mode)
            M_NEW:   sum_next = qv;
            M_ADD:   sum_next = sum_reg + qv;
            M_SUB:   sum_next = sum_reg - qv;
            default: sum_next = qv;
        endcase
    end
    assign det_zero  = (sum_next == '0);
    assign div_num   = {sat_sum(sum_next), {FRAC_BITS{1'b0}}};
    assign div_start = (state_reg == ST_ACC) && (uop.fin == F_DIV);
    assign emit      = (state_reg == ST_FIN) && last_reg && (!out_valid_reg || out_ready);

    // normal divide unit
    lbs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (det_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_INFL))
                begin
                    op_next    = '0;
                    state_next = apply_c ? ST_RD : ST_FIN;
                end
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC:
            begin
                priority if (uop.fin == F_DET && det_zero)
                    state_next = ST_FIN;
                else if (uop.fin == F_DIV)
                    state_next = ST_DIV;
                else if ((op_reg == POS_LAST_UOP && !normals_reg) || op_reg == LAST_UOP)
                    state_next = ST_FIN;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    op_next    = op_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (!last_reg || emit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // per-vertex control state, accumulators and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_reg   <= 1'b0;
            singular_reg  <= 1'b0;
            count_reg     <= '0;
            normals_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                normals_reg <= cfg_wdata;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (in_accept && (req_type == REQ_INFL))
            begin
                if (apply_c)
                    touched_reg <= 1'b1;
                if (int'(count_reg) < MAX_INFL)
                    count_reg <= count_reg + 1'b1;
            end
            if (state_reg == ST_ACC)
            begin
                if (uop.fin == F_ACC)
                    acc_reg[uop.k[2:0]] <= sat_add((ACC_W+1)'(acc_reg[uop.k[2:0]]) + wv);
                if (uop.fin == F_DET && det_zero)
                    singular_reg <= 1'b1;
            end
            if (emit)
            begin
                touched_reg   <= 1'b0;
                singular_reg  <= 1'b0;
                count_reg     <= '0;
                for (int i = 0; i < 6; i++)
                    acc_reg[i] <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept && (req_type == REQ_INFL))
        begin
            bone_reg   <= bone_index;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            nrm_reg[0] <= nrm_x;
            nrm_reg[1] <= nrm_y;
            nrm_reg[2] <= nrm_z;
            w_reg      <= w_clamp;
            last_reg   <= last_of_vertex;
        end
        if (state_reg == ST_MUL)
            prod_reg <= a_op * b_op;
        if (state_reg == ST_ACC)
        begin
            sum_reg <= sum_next;
            if (uop.fin == F_VAL)
                val_reg <= sat_sum(sum_next);
            if (uop.fin == F_COF)
                cof_reg[uop.k] <= sat_sum(sum_next);
            if (uop.fin == F_DET)
                det_reg <= sum_next;
        end
        if (state_reg == ST_DIV && div_done)
            val_reg <= sat_quo(div_q);
        if (emit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_data_reg[i]     <= sat_acc(acc_reg[i]);
                out_data_reg[i + 3] <= normals_reg ? sat_acc(acc_reg[i + 3]) : '0;
            end
            out_touched_reg  <= touched_reg;
            out_singular_reg <= singular_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_pos_x     = out_data_reg[0];
    assign out_pos_y     = out_data_reg[1];
    assign out_pos_z     = out_data_reg[2];
    assign out_nrm_x     = out_data_reg[3];
    assign out_nrm_y     = out_data_reg[4];
    assign out_nrm_z     = out_data_reg[5];
    assign touched       = out_touched_reg;
    assign singular_seen = out_singular_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= MAX_INFL)
        else $error("influence count out of range");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !div_done) |=> (state_reg == ST_DIV))
        else $error("sequencer left divide wait early");

    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (count_reg == '0 && !touched_reg && !singular_reg))
        else $error("vertex state not cleared after emit");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("output loaded outside finish step");
`endif

endmodule

@@ tb/linear_blend_skinning_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// linear_blend_skinning_core_tb: self-checking bench for the skinning core
// Loads a set of bones, runs a directed table and then random vertices through
// an in-bench fixed-point predictor, across idle/stall phases and both
// settings of the normals switch. Results are compared field by field.
// ============================================================================
module linear_blend_skinning_core_tb;
    import lbs_pkg::*;

    localparam int LATENCY_PAD  = 400;
    localparam int LOADED_BONES = 16;

    // one input word
    typedef struct {
        logic                     req;
        logic [BONE_W-1:0]        bone;
        logic [ELEM_W-1:0]        elem;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] px, py, pz, nx, ny, nz;
        logic [WGT_W-1:0]         wgt;
        logic                     last;
    } word_t;

    // one skinned vertex
    typedef struct {
        logic signed [DATA_W-1:0] px, py, pz, nx, ny, nz;
        logic                     touched;
        logic                     singular;
    } vertex_t;

    // directed row: word plus optional hand-typed result
    typedef struct {
        word_t   w;
        bit      typed;
        vertex_t r;
    } row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic                     cfg_wdata = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = 1'b0;
    logic [BONE_W-1:0]        bone_index = '0;
    logic [ELEM_W-1:0]        matrix_element = '0;
    logic signed [DATA_W-1:0] matrix_value = '0;
    logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [DATA_W-1:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
    logic [WGT_W-1:0]         weight = '0;
    logic                     last_of_vertex = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [DATA_W-1:0] out_nrm_x, out_nrm_y, out_nrm_z;
    logic                     touched;
    logic                     singular_seen;

    // predictor state
    longint  bone_mem [RAM_DEPTH];
    longint  acc_sum [6];
    bit      touch_q, sing_q, nrm_on;
    int      infl_cnt;
    vertex_t pending_vertices [$];
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    always #6 clk = ~clk;

    linear_blend_skinning_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .bone_index(bone_index),
        .matrix_element(matrix_element), .matrix_value(matrix_value),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .nrm_x(nrm_x), .nrm_y(nrm_y), .nrm_z(nrm_z),
        .weight(weight), .last_of_vertex(last_of_vertex),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
        .out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y), .out_nrm_z(out_nrm_z),
        .touched(touched), .singular_seen(singular_seen)
    );

    // ---------------- fixed-point helpers ----------------
    function automatic longint clamp_bits(input longint x, input int bits);
        longint hi, lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint cofactor(input longint a, input longint b,
                                        input longint c, input longint d);
        return clamp_bits(qmul(a, b) - qmul(c, d), 32);
    endfunction

    function automatic void blend_in(input int k, input longint v, input longint w);
        acc_sum[k] = clamp_bits(acc_sum[k] + ((v * w) >>> W_SHIFT), 48);
    endfunction

    // one influence into the accumulators
    function automatic void skin_influence(input word_t w);
        longint m [12];
        longint c [9];
        longint p [3];
        longint n [3];
        longint wt, det, s, t;
        wt = longint'(w.wgt);
        if (wt > 65536) wt = 65536;
        if (wt == 0 || int'(w.bone) >= MAX_BONES) return;
        touch_q = 1'b1;
        for (int i = 0; i < 12; i++) m[i] = bone_mem[int'(w.bone) * BONE_ELEMS + i];
        p[0] = w.px; p[1] = w.py; p[2] = w.pz;
        n[0] = w.nx; n[1] = w.ny; n[2] = w.nz;
        for (int i = 0; i < 3; i++) begin
            s = qmul(m[4*i], p[0]) + qmul(m[4*i+1], p[1]) + qmul(m[4*i+2], p[2])
                + m[4*i+3];
            blend_in(i, clamp_bits(s, 32), wt);
        end
        if (!nrm_on) return;
        c[0] = cofactor(m[5], m[10], m[6], m[9]);
        c[1] = cofactor(m[6], m[8],  m[4], m[10]);
        c[2] = cofactor(m[4], m[9],  m[5], m[8]);
        c[3] = cofactor(m[2], m[9],  m[1], m[10]);
        c[4] = cofactor(m[0], m[10], m[2], m[8]);
        c[5] = cofactor(m[1], m[8],  m[0], m[9]);
        c[6] = cofactor(m[1], m[6],  m[2], m[5]);
        c[7] = cofactor(m[2], m[4],  m[0], m[6]);
        c[8] = cofactor(m[0], m[5],  m[1], m[4]);
        det = qmul(m[0], c[0]) + qmul(m[1], c[1]) + qmul(m[2], c[2]);
        if (det == 0) begin
            sing_q = 1'b1;
            return;
        end
        for (int i = 0; i < 3; i++) begin
            t = qmul(c[3*i], n[0]) + qmul(c[3*i+1], n[1]) + qmul(c[3*i+2], n[2]);
            t = clamp_bits(t, 32) * (longint'(1) <<< FRAC_BITS);
            blend_in(3 + i, clamp_bits(t / det, 32), wt);
        end
    endfunction

    // full predictor step: returns 1 when a vertex is finished
    function automatic bit skin_word(input word_t w, output vertex_t r);
        longint v [6];
        r = '{default: '0};
        if (w.req == REQ_MATRIX) begin
            if (int'(w.bone) < MAX_BONES && int'(w.elem) < BONE_ELEMS)
                bone_mem[int'(w.bone) * BONE_ELEMS + int'(w.elem)] = longint'(w.val);
            return 1'b0;
        end
        if (infl_cnt < MAX_INFL) begin
            skin_influence(w);
            infl_cnt++;
        end
        if (!w.last) return 1'b0;
        for (int i = 0; i < 6; i++) begin
            v[i] = clamp_bits(acc_sum[i], 32);
            if (i >= 3 && !nrm_on) v[i] = 0;
            acc_sum[i] = 0;
        end
        r.px = v[0]; r.py = v[1]; r.pz = v[2];
        r.nx = v[3]; r.ny = v[4]; r.nz = v[5];
        r.touched = touch_q;
        r.singular = sing_q;
        touch_q = 1'b0;
        sing_q = 1'b0;
        infl_cnt = 0;
        return 1'b1;
    endfunction

    // ---------------- mismatch reporting ----------------
    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // ---------------- result side ----------------
    always @(posedge clk) begin
        vertex_t e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_vertices.size() == 0) begin
                report_mismatch("unexpected vertex", 1, 0);
            end
            else begin
                e = pending_vertices.pop_front();
                if (out_pos_x !== e.px) report_mismatch("out_pos_x", out_pos_x, e.px);
                if (out_pos_y !== e.py) report_mismatch("out_pos_y", out_pos_y, e.py);
                if (out_pos_z !== e.pz) report_mismatch("out_pos_z", out_pos_z, e.pz);
                if (out_nrm_x !== e.nx) report_mismatch("out_nrm_x", out_nrm_x, e.nx);
                if (out_nrm_y !== e.ny) report_mismatch("out_nrm_y", out_nrm_y, e.ny);
                if (out_nrm_z !== e.nz) report_mismatch("out_nrm_z", out_nrm_z, e.nz);
                if (touched !== e.touched) report_mismatch("touched", touched, e.touched);
                if (singular_seen !== e.singular)
                    report_mismatch("singular_seen", singular_seen, e.singular);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------- stimulus side ----------------
    // drive one word and wait for it to be taken; optional typed result
    task automatic send_word(input word_t w, input bit typed, input vertex_t tr);
        vertex_t r;
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= w.req;
        bone_index     <= w.bone;
        matrix_element <= w.elem;
        matrix_value   <= w.val;
        pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
        nrm_x <= w.nx; nrm_y <= w.ny; nrm_z <= w.nz;
        weight         <= w.wgt;
        last_of_vertex <= w.last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (skin_word(w, r)) pending_vertices.push_back(typed ? tr : r);
    endtask

    // park the sender until the block has drained
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic set_normals(input bit on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we    <= 1'b0;
        nrm_on = on;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_q();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return D_MAX;
            2:       return D_MIN;
            3:       return '0;
            default: return DATA_W'(int'($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return WGT_ONE;
            3:       return WGT_W'($urandom_range(131071, 65537));
            default: return WGT_W'($urandom_range(65536, 1));
        endcase
    endfunction

    function automatic word_t matrix_word(input int bone, input int el, input int v);
        word_t w;
        w = '{default: '0};
        w.req = REQ_MATRIX;
        w.bone = BONE_W'(bone);
        w.elem = ELEM_W'(el);
        w.val = v;
        return w;
    endfunction

    function automatic word_t infl_word(input int bone, input int wt, input bit last,
                                        input int px, input int py, input int pz,
                                        input int nx, input int ny, input int nz);
        word_t w;
        w = '{req: REQ_INFL, bone: BONE_W'(bone), elem: '0, val: '0,
              px: px, py: py, pz: pz, nx: nx, ny: ny, nz: nz,
              wgt: WGT_W'(wt), last: last};
        return w;
    endfunction

    // random vertex of one to six influences, with stray matrix writes
    task automatic random_vertex();
        int cnt;
        word_t w;
        vertex_t none;
        none = '{default: '0};
        cnt = $urandom_range(6, 1);
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(9) == 0) begin
                w = matrix_word($urandom_range(LOADED_BONES - 1, 2), $urandom_range(15),
                                ($urandom_range(3) == 0) ? 0 : rand_q());
                send_word(w, 1'b0, none);
            end
            w = '{req: REQ_INFL,
                  bone: ($urandom_range(9) == 0) ? BONE_W'(1)
                        : BONE_W'($urandom_range(LOADED_BONES - 1)),
                  elem: ELEM_W'($urandom), val: $urandom,
                  px: rand_q(), py: rand_q(), pz: rand_q(),
                  nx: rand_q(), ny: rand_q(), nz: rand_q(),
                  wgt: rand_weight(), last: (i == cnt - 1)};
            send_word(w, 1'b0, none);
        end
    endtask

    // ---------------- main sequence ----------------
    initial begin
        row_t    rows [$];
        vertex_t none;
        word_t   w;
        int      nrm_plan [5];
        int      send_plan [5];
        int      recv_plan [5];

        nrm_plan  = '{1, 0, 1, 0, 1};
        send_plan = '{0, 75, 0, 12, 0};
        recv_plan = '{0, 0, 75, 12, 0};
        none = '{default: '0};
        for (int i = 0; i < 6; i++) acc_sum[i] = 0;
        for (int i = 0; i < RAM_DEPTH; i++) bone_mem[i] = 0;
        touch_q = 1'b0; sing_q = 1'b0; infl_cnt = 0; nrm_on = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the bone set: 0 identity, 1 singular with translation, rest random
        for (int b = 0; b < LOADED_BONES; b++) begin
            for (int e = 0; e < BONE_ELEMS; e++) begin
                if (b == 0)
                    w = matrix_word(b, e, (e == 0 || e == 5 || e == 10) ? Q_ONE : 0);
                else if (b == 1)
                    w = matrix_word(b, e, (e % 4 == 3) ? ((e / 4 + 1) << 16) : 0);
                else
                    w = matrix_word(b, e, rand_q());
                send_word(w, 1'b0, none);
            end
        end

        // directed table
        rows.push_back('{infl_word(0, 0, 1, 1 << 16, 2 << 16, 3 << 16, 0, 0, 0),
                        1'b1, '{0, 0, 0, 0, 0, 0, 1'b0, 1'b0}});
        rows.push_back('{infl_word(0, 65536, 1, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0),
                        1'b1, '{1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0, 1'b1, 1'b0}});
        rows.push_back('{infl_word(1, 65536, 1, 5 << 16, 5 << 16, 5 << 16,
                                   1 << 16, 0, 0),
                        1'b1, '{1 << 16, 2 << 16, 3 << 16, 0, 0, 0, 1'b1, 1'b1}});
        rows.push_back('{infl_word(0, 131071, 1, -(7 << 16), 3, -1, 1 << 16, 1 << 16, 0),
                        1'b0, none});
        rows.push_back('{infl_word(LOADED_BONES - 1, 65536, 1, D_MAX, D_MIN, D_MAX,
                                   D_MIN, D_MAX, D_MIN),
                        1'b0, none});
        rows.push_back('{infl_word(5, 30000, 0, 1 << 16, 0, 0, 0, 1 << 16, 0), 1'b0, none});
        rows.push_back('{infl_word(6, 20000, 0, 0, 1 << 16, 0, 1 << 16, 0, 0), 1'b0, none});
        rows.push_back('{infl_word(7, 0, 0, 9 << 16, 9 << 16, 9 << 16, 0, 0, 1 << 16),
                        1'b0, none});
        rows.push_back('{infl_word(8, 15536, 0, -(1 << 16), 2, 3, 0, 0, 1 << 16),
                        1'b0, none});
        rows.push_back('{infl_word(9, 65536, 1, 4 << 16, 4 << 16, 4 << 16, 1, 1, 1),
                        1'b0, none});
        rows.push_back('{matrix_word(0, 12, 32'h5a5a5a5a), 1'b0, none});
        rows.push_back('{matrix_word(0, 15, 32'hffffffff), 1'b0, none});
        rows.push_back('{infl_word(0, 65536, 1, 1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0),
                        1'b1, '{1 << 16, 2 << 16, 3 << 16, 0, 1 << 16, 0, 1'b1, 1'b0}});
        rows.push_back('{matrix_word(2, 3, D_MIN), 1'b0, none});
        rows.push_back('{infl_word(2, 65536, 1, 1 << 16, 1 << 16, 1 << 16,
                                   1 << 16, 1 << 16, 1 << 16), 1'b0, none});
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);

        // random phases across idle patterns and both normal settings
        for (int ph = 0; ph < 5; ph++) begin
            drain_block();
            set_normals(nrm_plan[ph]);
            send_idle_pct  = send_plan[ph];
            recv_stall_pct = recv_plan[ph];
            for (int v = 0; v < 20; v++) random_vertex();
        end

        drain_block();
        if (errors == 0 && pending_vertices.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
src/lbs_pkg.sv
src/lbs_bone_ram.sv
src/lbs_div.sv
src/linear_blend_skinning_core.sv
tb/linear_blend_skinning_core_tb.sv
